[rtl/fcull_pkg.sv]
// Shared types and constants for the frustum culling test block.
package fcull_pkg;

   // Primitive kind carried on the request tuser bits.
   typedef enum logic [1:0] {
      ACT_BOX      = 2'd0,
      ACT_POINT    = 2'd1,
      ACT_SEGMENT  = 2'd2,
      ACT_TRIANGLE = 2'd3
   } action_type;

   // Configuration register indexes.
   localparam logic [2:0] REG_PLANE_0    = 3'd0;
   localparam logic [2:0] REG_PLANE_1    = 3'd1;
   localparam logic [2:0] REG_PLANE_2    = 3'd2;
   localparam logic [2:0] REG_PLANE_3    = 3'd3;
   localparam logic [2:0] REG_PLANE_4    = 3'd4;
   localparam logic [2:0] REG_PLANE_5    = 3'd5;
   localparam logic [2:0] REG_REGION_MIN = 3'd6;
   localparam logic [2:0] REG_REGION_MAX = 3'd7;

   localparam int PLANE_SLOTS  = 6;
   localparam int FIELD_BITS   = 16;
   localparam int NUM_FIELDS   = 9;
   localparam int PLANE_BITS   = 64;
   localparam int REGION_BITS  = 48;
   localparam int CSR_IDX_BITS = 3;
   localparam int REQ_DATA_BITS = NUM_FIELDS * FIELD_BITS;
   localparam int RSP_DATA_BITS = 8;

   // Normal parts are Q1.14, so the offset is scaled by 2^14 for a point
   // distance and by 2^15 for a doubled box-center distance.
   localparam int QSHIFT     = 14;
   localparam int BOX_SHIFT  = QSHIFT + 1;

   localparam logic [PLANE_BITS-1:0]  PLANE_RESET      = '0;
   localparam logic [REGION_BITS-1:0] REGION_MIN_RESET = 48'h8000_8000_8000;
   localparam logic [REGION_BITS-1:0] REGION_MAX_RESET = 48'h7FFF_7FFF_7FFF;

endpackage

[rtl/frustum_cull_test.sv]
// Pipelined view-frustum visibility test for boxes, points, segments and triangles.
//
// Usage: a primitive arrives as one transfer on the req_ stream. req_tuser
// carries its kind (box, point, segment or triangle) and req_tdata carries the
// nine coordinates a.x, a.y, a.z, b.x, b.y, b.z, c.x, c.y, c.z, 16 bits each.
// Each primitive produces exactly one transfer on the rsp_ stream whose bit 0
// is the visible flag. Planes and the region box are loaded through the csr_
// write port; the user must write them only while no primitive is in flight,
// as the block does not enforce this. Throughput is one primitive per cycle
// while rsp_tready stays high: the pipeline has five register stages (capture,
// operand add, multiply, distance sum, compare/output) and each stage moves
// independently, so bubbles close up behind a stalled output.
// The multiply stage holds nine multipliers per plane, which sets the area.
// When the receiver holds rsp_tready low the result stays put and the stages
// behind it fill up; req_tready drops only when every stage is occupied.
// Reset empties the pipeline, clears the planes to zero (never culling) and
// opens the region box to the full signed 16-bit range.
module frustum_cull_test
   import fcull_pkg::*;
#(
   parameter int NUM_PLANES = 6,
   parameter int COORD_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   // Request stream.
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // req_tdata fields from bit 0 up: point_a_x, point_a_y, point_a_z,
   // point_b_x, point_b_y, point_b_z, point_c_x, point_c_y, point_c_z.
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // req_tuser fields from bit 0 up: action.
   input  logic [1:0]               req_tuser,
   // Response stream.
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // rsp_tdata fields from bit 0 up: visible, then zero fill.
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   // Configuration write port.
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [PLANE_BITS-1:0]    csr_wdata
);

   // Coordinate, operand, product and sum widths.
   localparam int CB = COORD_BITS;
   localparam int OW = CB + 1;
   localparam int PW = FIELD_BITS + OW;
   localparam int SW = ((PW > 31) ? PW : 31) + 2;
   localparam int RW = (CB > FIELD_BITS) ? CB : FIELD_BITS;

   // Configuration registers.
   logic [PLANE_BITS-1:0]  plane_ff [PLANE_SLOTS];
   logic [REGION_BITS-1:0] region_min_ff;
   logic [REGION_BITS-1:0] region_max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < PLANE_SLOTS; p++) begin
            plane_ff[p] <= PLANE_RESET;
         end
         region_min_ff <= REGION_MIN_RESET;
         region_max_ff <= REGION_MAX_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_PLANE_0:    plane_ff[0] <= csr_wdata;
            REG_PLANE_1:    plane_ff[1] <= csr_wdata;
            REG_PLANE_2:    plane_ff[2] <= csr_wdata;
            REG_PLANE_3:    plane_ff[3] <= csr_wdata;
            REG_PLANE_4:    plane_ff[4] <= csr_wdata;
            REG_PLANE_5:    plane_ff[5] <= csr_wdata;
            REG_REGION_MIN: region_min_ff <= csr_wdata[REGION_BITS-1:0];
            REG_REGION_MAX: region_max_ff <= csr_wdata[REGION_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Stage enables: a stage loads when it is empty or its successor moves.
   logic out_en, s4_en, s3_en, s2_en, s1_en;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, rsp_tvalid_ff;

   assign out_en     = !rsp_tvalid_ff || rsp_tready;
   assign s4_en      = !s4_valid_ff || out_en;
   assign s3_en      = !s3_valid_ff || s4_en;
   assign s2_en      = !s2_valid_ff || s3_en;
   assign s1_en      = !s1_valid_ff || s2_en;
   assign req_tready = s1_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         s4_valid_ff   <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (s1_en)  s1_valid_ff   <= req_tvalid;
         if (s2_en)  s2_valid_ff   <= s1_valid_ff;
         if (s3_en)  s3_valid_ff   <= s2_valid_ff;
         if (s4_en)  s4_valid_ff   <= s3_valid_ff;
         if (out_en) rsp_tvalid_ff <= s4_valid_ff;
      end
   end

   // Stage 1: capture. Takes COORD_BITS bits per field, zero-extending past 16.
   logic signed [CB-1:0] req_coord [NUM_FIELDS];

   for (genvar f = 0; f < NUM_FIELDS; f++) begin : g_coord
      if (CB <= FIELD_BITS) begin : g_narrow
         assign req_coord[f] = req_tdata[FIELD_BITS*f +: CB];
      end else begin : g_wide
         assign req_coord[f] = {{(CB-FIELD_BITS){1'b0}}, req_tdata[FIELD_BITS*f +: FIELD_BITS]};
      end
   end

   action_type           s1_action_ff;
   logic signed [CB-1:0] s1_coord_ff [NUM_FIELDS];

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_action_ff <= action_type'(req_tuser);
         for (int f = 0; f < NUM_FIELDS; f++) begin
            s1_coord_ff[f] <= req_coord[f];
         end
      end
   end

   // Stage 2: multiplier operands. A box feeds a+b and b-a per axis; the
   // other kinds feed their points straight through. Region overlap is
   // resolved here as well.
   logic signed [OW-1:0] s2_op_in [NUM_FIELDS];
   logic                 s2_region_ok_in;

   always_comb begin
      logic signed [OW-1:0] av, bv;
      logic signed [RW-1:0] ax, bx, lo, hi;
      s2_region_ok_in = 1'b1;
      for (int k = 0; k < 3; k++) begin
         av = OW'(s1_coord_ff[k]);
         bv = OW'(s1_coord_ff[3+k]);
         if (s1_action_ff == ACT_BOX) begin
            s2_op_in[k]   = av + bv;
            s2_op_in[3+k] = bv - av;
            s2_op_in[6+k] = '0;
         end else begin
            s2_op_in[k]   = av;
            s2_op_in[3+k] = bv;
            s2_op_in[6+k] = OW'(s1_coord_ff[6+k]);
         end
         ax = RW'(s1_coord_ff[k]);
         bx = RW'(s1_coord_ff[3+k]);
         lo = RW'($signed(region_min_ff[FIELD_BITS*k +: FIELD_BITS]));
         hi = RW'($signed(region_max_ff[FIELD_BITS*k +: FIELD_BITS]));
         if (!(ax <= hi && bx >= lo)) begin
            s2_region_ok_in = 1'b0;
         end
      end
   end

   action_type           s2_action_ff;
   logic                 s2_region_ok_ff;
   logic signed [OW-1:0] s2_op_ff [NUM_FIELDS];

   always_ff @(posedge clock) begin
      if (s2_en) begin
         s2_action_ff    <= s1_action_ff;
         s2_region_ok_ff <= s2_region_ok_in;
         for (int f = 0; f < NUM_FIELDS; f++) begin
            s2_op_ff[f] <= s2_op_in[f];
         end
      end
   end

   // Stage 3: nine products per plane, normal part times operand.
   logic signed [PW-1:0] s3_prod_in [NUM_PLANES][NUM_FIELDS];

   always_comb begin
      logic signed [FIELD_BITS-1:0] nv;
      for (int p = 0; p < NUM_PLANES; p++) begin
         for (int f = 0; f < NUM_FIELDS; f++) begin
            nv = plane_ff[p][FIELD_BITS*(f%3) +: FIELD_BITS];
            s3_prod_in[p][f] = PW'(nv) * PW'(s2_op_ff[f]);
         end
      end
   end

   action_type           s3_action_ff;
   logic                 s3_region_ok_ff;
   logic signed [PW-1:0] s3_prod_ff [NUM_PLANES][NUM_FIELDS];

   always_ff @(posedge clock) begin
      if (s3_en) begin
         s3_action_ff    <= s2_action_ff;
         s3_region_ok_ff <= s2_region_ok_ff;
         s3_prod_ff      <= s3_prod_in;
      end
   end

   // Stage 4: distances. A box gives the doubled center distance and the
   // doubled radius; the other kinds give one distance per point.
   logic signed [SW-1:0] s4_da_in [NUM_PLANES];
   logic signed [SW-1:0] s4_db_in [NUM_PLANES];
   logic signed [SW-1:0] s4_dc_in [NUM_PLANES];

   always_comb begin
      logic signed [FIELD_BITS-1:0] off_v;
      logic signed [SW-1:0]         off_w;
      logic signed [PW:0]           t_v;
      logic signed [PW:0]           abs_v [3];
      for (int p = 0; p < NUM_PLANES; p++) begin
         off_v = plane_ff[p][PLANE_BITS-1 -: FIELD_BITS];
         off_w = SW'(off_v);
         for (int k = 0; k < 3; k++) begin
            t_v      = (PW+1)'(s3_prod_ff[p][3+k]);
            abs_v[k] = t_v[PW] ? -t_v : t_v;
         end
         if (s3_action_ff == ACT_BOX) begin
            s4_da_in[p] = SW'(s3_prod_ff[p][0]) + SW'(s3_prod_ff[p][1])
                        + SW'(s3_prod_ff[p][2]) + (off_w <<< BOX_SHIFT);
            s4_db_in[p] = SW'(abs_v[0]) + SW'(abs_v[1]) + SW'(abs_v[2]);
            s4_dc_in[p] = '0;
         end else begin
            s4_da_in[p] = SW'(s3_prod_ff[p][0]) + SW'(s3_prod_ff[p][1])
                        + SW'(s3_prod_ff[p][2]) + (off_w <<< QSHIFT);
            s4_db_in[p] = SW'(s3_prod_ff[p][3]) + SW'(s3_prod_ff[p][4])
                        + SW'(s3_prod_ff[p][5]) + (off_w <<< QSHIFT);
            s4_dc_in[p] = SW'(s3_prod_ff[p][6]) + SW'(s3_prod_ff[p][7])
                        + SW'(s3_prod_ff[p][8]) + (off_w <<< QSHIFT);
         end
      end
   end

   action_type           s4_action_ff;
   logic                 s4_region_ok_ff;
   logic signed [SW-1:0] s4_da_ff [NUM_PLANES];
   logic signed [SW-1:0] s4_db_ff [NUM_PLANES];
   logic signed [SW-1:0] s4_dc_ff [NUM_PLANES];

   always_ff @(posedge clock) begin
      if (s4_en) begin
         s4_action_ff    <= s3_action_ff;
         s4_region_ok_ff <= s3_region_ok_ff;
         s4_da_ff        <= s4_da_in;
         s4_db_ff        <= s4_db_in;
         s4_dc_ff        <= s4_dc_in;
      end
   end

   // Stage 5: per-plane behind decision and the visible flag. A box is
   // behind when 2d + 2r <= 0 and d < 0; a point set is behind when every
   // point it uses lies on the negative side.
   logic [NUM_PLANES-1:0] behind;
   logic                  rsp_visible_in;

   always_comb begin
      logic signed [SW:0] edge_sum;
      for (int p = 0; p < NUM_PLANES; p++) begin
         edge_sum = (SW+1)'(s4_da_ff[p]) + (SW+1)'(s4_db_ff[p]);
         if (s4_action_ff == ACT_BOX) begin
            behind[p] = (edge_sum[SW] || edge_sum == '0) && s4_da_ff[p][SW-1];
         end else begin
            behind[p] = s4_da_ff[p][SW-1]
                      && (s4_action_ff == ACT_POINT || s4_db_ff[p][SW-1])
                      && (s4_action_ff != ACT_TRIANGLE || s4_dc_ff[p][SW-1]);
         end
      end
      rsp_visible_in = !(|behind) && (s4_action_ff != ACT_BOX || s4_region_ok_ff);
   end

   logic rsp_visible_ff;

   always_ff @(posedge clock) begin
      if (out_en) begin
         rsp_visible_ff <= rsp_visible_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(RSP_DATA_BITS-1){1'b0}}, rsp_visible_ff};

`ifndef SYNTHESIS
   // An accepted primitive always occupies the capture stage next cycle.
   a_accept_captured: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> s1_valid_ff)
      else $error("accepted primitive not captured");

   // A finished distance stage always produces a response when it moves.
   a_result_delivered: assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff && out_en |=> rsp_tvalid_ff)
      else $error("result lost between last stage and output");

   // A full pipeline behind a stalled output must refuse new primitives.
   a_full_backpressure: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s2_valid_ff && s3_valid_ff && s4_valid_ff
      && rsp_tvalid_ff && !rsp_tready |-> !req_tready)
      else $error("pipeline accepted a primitive while full");

   // A box outside the region box is never reported visible.
   a_region_cull: assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff && out_en && s4_action_ff == ACT_BOX && !s4_region_ok_ff
      |=> !rsp_tdata[0])
      else $error("box outside region reported visible");
`endif

endmodule
